FILE: rtl/s64rp_pkg.sv
package s64rp_pkg;

  localparam int unsigned DATA_W = 64;
  localparam int unsigned CMD_W = 6;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned SW_W = 3;

  localparam logic [SW_W-1:0] SW_NONE   = 3'd0;
  localparam logic [SW_W-1:0] SW_BYTE   = 3'd1;
  localparam logic [SW_W-1:0] SW_HALF   = 3'd2;
  localparam logic [SW_W-1:0] SW_WORD   = 3'd3;
  localparam logic [SW_W-1:0] SW_DOUBLE = 3'd4;

  localparam logic ST_OK       = 1'b0;
  localparam logic ST_BAD_KIND = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_GOT_BASE        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TLS_BLOCK_START = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THREAD_POINTER  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TLS_HELPER_ADDR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TLS_MODULE_SLOT = 3'd4;

  localparam logic [12:0] LO10_MASK = 13'h03ff;
  localparam logic [12:0] LOX_SET   = 13'h1c00;

  typedef enum logic [CMD_W-1:0] {
    CMD_R5, CMD_R6, CMD_R7, CMD_R8, CMD_R10, CMD_R11, CMD_R13, CMD_R22,
    CMD_R16, CMD_R32, CMD_DISP8, CMD_DISP16, CMD_DISP32, CMD_WDISP22,
    CMD_WDISP30, CMD_HI22, CMD_GOT10, CMD_GOT13, CMD_GOT22,
    CMD_GOTDATA_HIX22, CMD_GOTDATA_OP_HIX22, CMD_GOTDATA_LOX10,
    CMD_GOTDATA_OP_LOX10, CMD_GOTDATA_OP, CMD_PC10, CMD_PC22, CMD_OLO10,
    CMD_HH22, CMD_HM10, CMD_PC_HH22, CMD_PC_HM10, CMD_WDISP16, CMD_WDISP19,
    CMD_DISP64, CMD_R64, CMD_HIX22, CMD_LOX10, CMD_H44, CMD_M44, CMD_L44,
    CMD_TLS_GD_HI22, CMD_TLS_GD_LO10, CMD_TLS_CALL, CMD_TLS_LDM_HI22,
    CMD_TLS_LDM_LO10, CMD_TLS_LDO_HIX22, CMD_TLS_LDO_LOX10, CMD_TLS_IE_HI22,
    CMD_TLS_IE_LO10, CMD_TLS_LE_HIX22, CMD_TLS_LE_LOX10, CMD_SIZE32,
    CMD_TLS_MARKER
  } cmd_t;

endpackage

FILE: rtl/sparc64_relocation_patcher_core.sv
// SPARC64 relocation patcher. Each item carries one relocation and yields one
// result: the patched site contents, right-aligned, with its store width and a
// status flag for unknown kinds. The datapath is a three-stage pipeline: stage
// one selects operands and forms one 64-bit sum, stage two subtracts the place,
// a base register or zero, stage three cuts the bit field, ORs it into the low
// half of the old word or takes it alone for full-width kinds, and registers it.
// One item is accepted every cycle unless the output stalls; each stage holds
// under back-pressure. The user must write the five base registers through the
// configuration port only while no item is in flight (unchecked in the block).
module sparc64_relocation_patcher_core (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [s64rp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [s64rp_pkg::DATA_W-1:0]           cfg_wdata,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [s64rp_pkg::CMD_W-1:0]            cmd,
  input  logic [s64rp_pkg::DATA_W-1:0]           sym_addr,
  input  logic signed [s64rp_pkg::DATA_W-1:0]    addend,
  input  logic [s64rp_pkg::DATA_W-1:0]           place,
  input  logic [s64rp_pkg::DATA_W-1:0]           got_entry_addr,
  input  logic [s64rp_pkg::DATA_W-1:0]           tlsgd_addr,
  input  logic [s64rp_pkg::DATA_W-1:0]           gottp_addr,
  input  logic [s64rp_pkg::DATA_W-1:0]           sym_size,
  input  logic [s64rp_pkg::DATA_W-1:0]           old_word,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [s64rp_pkg::DATA_W-1:0]           new_word,
  output logic [s64rp_pkg::SW_W-1:0]             store_width,
  output logic                                   status
);

  logic [63:0] got_base;
  logic [63:0] tls_block_start;
  logic [63:0] thread_pointer;
  logic [63:0] tls_helper_addr;
  logic [63:0] tls_module_slot;

  logic              s1_valid;
  s64rp_pkg::cmd_t   s1_cmd;
  logic [63:0]       s1_sum;
  logic [63:0]       s1_sub;
  logic [31:0]       s1_old;

  logic              s2_valid;
  s64rp_pkg::cmd_t   s2_cmd;
  logic [63:0]       s2_val;
  logic [31:0]       s2_old;

  logic s1_adv;
  logic s2_adv;
  logic s3_adv;

  s64rp_pkg::cmd_t in_cmd;
  logic [63:0] op_x;
  logic [63:0] op_y;
  logic [63:0] op_z;

  logic [63:0]                   fmt_field;
  logic                          fmt_ovr;
  logic [s64rp_pkg::SW_W-1:0]    fmt_width;
  logic                          fmt_status;
  logic [63:0]                   new_word_next;

  assign s3_adv   = !out_valid || out_ready;
  assign s2_adv   = !s2_valid || s3_adv;
  assign s1_adv   = !s1_valid || s2_adv;
  assign in_ready = s1_adv;

  assign in_cmd = s64rp_pkg::cmd_t'(cmd);

  // operand select: value = x + y - z
  always_comb begin
    op_x = sym_addr;
    op_y = addend;
    op_z = '0;
    unique case (in_cmd) inside
      s64rp_pkg::CMD_DISP8, s64rp_pkg::CMD_DISP16, s64rp_pkg::CMD_DISP32,
      s64rp_pkg::CMD_WDISP22, s64rp_pkg::CMD_WDISP30, s64rp_pkg::CMD_PC10,
      s64rp_pkg::CMD_PC22, s64rp_pkg::CMD_PC_HH22, s64rp_pkg::CMD_PC_HM10,
      s64rp_pkg::CMD_WDISP16, s64rp_pkg::CMD_WDISP19,
      s64rp_pkg::CMD_DISP64: begin
        op_z = place;
      end
      s64rp_pkg::CMD_GOT10, s64rp_pkg::CMD_GOT13, s64rp_pkg::CMD_GOT22,
      s64rp_pkg::CMD_GOTDATA_OP_HIX22, s64rp_pkg::CMD_GOTDATA_OP_LOX10: begin
        op_x = got_entry_addr;
        op_y = '0;
        op_z = got_base;
      end
      s64rp_pkg::CMD_GOTDATA_HIX22, s64rp_pkg::CMD_GOTDATA_LOX10: begin
        op_z = got_base;
      end
      s64rp_pkg::CMD_TLS_GD_HI22, s64rp_pkg::CMD_TLS_GD_LO10: begin
        op_x = tlsgd_addr;
        op_z = got_base;
      end
      s64rp_pkg::CMD_TLS_CALL: begin
        op_x = tls_helper_addr;
        op_z = place;
      end
      s64rp_pkg::CMD_TLS_LDM_HI22, s64rp_pkg::CMD_TLS_LDM_LO10: begin
        op_x = tls_module_slot;
        op_z = got_base;
      end
      s64rp_pkg::CMD_TLS_LDO_HIX22, s64rp_pkg::CMD_TLS_LDO_LOX10: begin
        op_z = tls_block_start;
      end
      s64rp_pkg::CMD_TLS_IE_HI22, s64rp_pkg::CMD_TLS_IE_LO10: begin
        op_x = gottp_addr;
        op_z = got_base;
      end
      s64rp_pkg::CMD_TLS_LE_HIX22, s64rp_pkg::CMD_TLS_LE_LOX10: begin
        op_z = thread_pointer;
      end
      s64rp_pkg::CMD_SIZE32: begin
        op_x = sym_size;
      end
      default: begin
        op_z = '0;
      end
    endcase
  end

  // field cut and merge
  always_comb begin
    fmt_field  = '0;
    fmt_ovr    = 1'b0;
    fmt_width  = s64rp_pkg::SW_WORD;
    fmt_status = s64rp_pkg::ST_OK;
    unique case (s2_cmd) inside
      s64rp_pkg::CMD_R5:  fmt_field = 64'(s2_val[4:0]);
      s64rp_pkg::CMD_R6:  fmt_field = 64'(s2_val[5:0]);
      s64rp_pkg::CMD_R7:  fmt_field = 64'(s2_val[6:0]);
      s64rp_pkg::CMD_R11: fmt_field = 64'(s2_val[10:0]);
      s64rp_pkg::CMD_R13, s64rp_pkg::CMD_GOT13: fmt_field = 64'(s2_val[12:0]);
      s64rp_pkg::CMD_R22: fmt_field = 64'(s2_val[21:0]);
      s64rp_pkg::CMD_R8, s64rp_pkg::CMD_DISP8: begin
        fmt_field = 64'(s2_val[7:0]);
        fmt_width = s64rp_pkg::SW_BYTE;
        fmt_ovr   = 1'b1;
      end
      s64rp_pkg::CMD_R16, s64rp_pkg::CMD_DISP16: begin
        fmt_field = 64'(s2_val[15:0]);
        fmt_width = s64rp_pkg::SW_HALF;
        fmt_ovr   = 1'b1;
      end
      s64rp_pkg::CMD_R32, s64rp_pkg::CMD_DISP32, s64rp_pkg::CMD_SIZE32: begin
        fmt_field = 64'(s2_val[31:0]);
        fmt_ovr   = 1'b1;
      end
      s64rp_pkg::CMD_DISP64, s64rp_pkg::CMD_R64: begin
        fmt_field = s2_val;
        fmt_width = s64rp_pkg::SW_DOUBLE;
        fmt_ovr   = 1'b1;
      end
      s64rp_pkg::CMD_R10, s64rp_pkg::CMD_GOT10, s64rp_pkg::CMD_PC10,
      s64rp_pkg::CMD_OLO10, s64rp_pkg::CMD_TLS_GD_LO10,
      s64rp_pkg::CMD_TLS_LDM_LO10, s64rp_pkg::CMD_TLS_LDO_LOX10,
      s64rp_pkg::CMD_TLS_IE_LO10: fmt_field = 64'(s2_val[9:0]);
      s64rp_pkg::CMD_HI22, s64rp_pkg::CMD_GOT22, s64rp_pkg::CMD_PC22,
      s64rp_pkg::CMD_TLS_GD_HI22, s64rp_pkg::CMD_TLS_LDM_HI22,
      s64rp_pkg::CMD_TLS_LDO_HIX22,
      s64rp_pkg::CMD_TLS_IE_HI22: fmt_field = 64'(s2_val[31:10]);
      s64rp_pkg::CMD_HIX22, s64rp_pkg::CMD_TLS_LE_HIX22:
        fmt_field = 64'(s2_val[31:10] ^ 22'h3f_ffff);
      s64rp_pkg::CMD_LOX10, s64rp_pkg::CMD_TLS_LE_LOX10:
        fmt_field = 64'((13'(s2_val[9:0]) & s64rp_pkg::LO10_MASK) | s64rp_pkg::LOX_SET);
      s64rp_pkg::CMD_GOTDATA_HIX22, s64rp_pkg::CMD_GOTDATA_OP_HIX22:
        fmt_field = 64'(s2_val[31:10] ^ s2_val[52:31]);
      s64rp_pkg::CMD_GOTDATA_LOX10, s64rp_pkg::CMD_GOTDATA_OP_LOX10:
        fmt_field = 64'({s2_val[43:41], s2_val[9:0]});
      s64rp_pkg::CMD_WDISP22: fmt_field = 64'(s2_val[23:2]);
      s64rp_pkg::CMD_WDISP30, s64rp_pkg::CMD_TLS_CALL:
        fmt_field = 64'(s2_val[31:2]);
      s64rp_pkg::CMD_WDISP19: fmt_field = 64'(s2_val[20:2]);
      s64rp_pkg::CMD_WDISP16:
        fmt_field = 64'({s2_val[17:16], 6'd0, s2_val[15:2]});
      s64rp_pkg::CMD_HH22, s64rp_pkg::CMD_PC_HH22:
        fmt_field = 64'(s2_val[63:42]);
      s64rp_pkg::CMD_HM10, s64rp_pkg::CMD_PC_HM10:
        fmt_field = 64'(s2_val[41:32]);
      s64rp_pkg::CMD_H44: fmt_field = 64'(s2_val[43:22]);
      s64rp_pkg::CMD_M44: fmt_field = 64'(s2_val[21:12]);
      s64rp_pkg::CMD_L44: fmt_field = 64'(s2_val[11:0]);
      s64rp_pkg::CMD_GOTDATA_OP, s64rp_pkg::CMD_TLS_MARKER: begin
        fmt_width = s64rp_pkg::SW_NONE;
      end
      default: begin
        fmt_width  = s64rp_pkg::SW_NONE;
        fmt_status = s64rp_pkg::ST_BAD_KIND;
      end
    endcase
  end

  always_comb begin
    if (fmt_width == s64rp_pkg::SW_NONE) begin
      new_word_next = '0;
    end else if (fmt_ovr) begin
      new_word_next = fmt_field;
    end else begin
      new_word_next = {32'd0, s2_old | fmt_field[31:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      got_base        <= '0;
      tls_block_start <= '0;
      thread_pointer  <= '0;
      tls_helper_addr <= '0;
      tls_module_slot <= '0;
      s1_valid        <= 1'b0;
      s2_valid        <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          s64rp_pkg::CFG_GOT_BASE:        got_base        <= cfg_wdata;
          s64rp_pkg::CFG_TLS_BLOCK_START: tls_block_start <= cfg_wdata;
          s64rp_pkg::CFG_THREAD_POINTER:  thread_pointer  <= cfg_wdata;
          s64rp_pkg::CFG_TLS_HELPER_ADDR: tls_helper_addr <= cfg_wdata;
          s64rp_pkg::CFG_TLS_MODULE_SLOT: tls_module_slot <= cfg_wdata;
          default: ;
        endcase
      end
      if (s1_adv) s1_valid <= in_valid;
      if (s2_adv) s2_valid <= s1_valid;
      if (s3_adv) out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_cmd <= in_cmd;
      s1_sum <= op_x + op_y;
      s1_sub <= op_z;
      s1_old <= old_word[31:0];
    end
    if (s2_adv) begin
      s2_cmd <= s1_cmd;
      s2_val <= s1_sum - s1_sub;
      s2_old <= s1_old;
    end
    if (s3_adv) begin
      new_word    <= new_word_next;
      store_width <= fmt_width;
      status      <= fmt_status;
    end
  end

endmodule

FILE: rtl/s64rp_checker.sv
module s64rp_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [s64rp_pkg::DATA_W-1:0]       new_word,
  input logic [s64rp_pkg::SW_W-1:0]         store_width,
  input logic                               status
);

  a_width_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> store_width <= s64rp_pkg::SW_DOUBLE)
    else $error("store width out of range");

  a_bad_kind_silent: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == s64rp_pkg::ST_BAD_KIND) |->
      (store_width == s64rp_pkg::SW_NONE && new_word == '0))
    else $error("unknown kind produced a write");

  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && store_width == s64rp_pkg::SW_NONE) |-> new_word == '0)
    else $error("no-write result carries data");

  a_right_aligned: assert property (@(posedge clk) disable iff (rst)
    out_valid |->
      ((store_width == s64rp_pkg::SW_BYTE && new_word[63:8] == '0) ||
       (store_width == s64rp_pkg::SW_HALF && new_word[63:16] == '0) ||
       (store_width == s64rp_pkg::SW_WORD && new_word[63:32] == '0) ||
       store_width == s64rp_pkg::SW_DOUBLE || store_width == s64rp_pkg::SW_NONE))
    else $error("patched word exceeds store width");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(new_word) && $stable(store_width) && $stable(status)))
    else $error("stalled result changed");

endmodule

bind sparc64_relocation_patcher_core s64rp_checker u_s64rp_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .new_word    (new_word),
  .store_width (store_width),
  .status      (status)
);

FILE: tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import s64rp_pkg::*;

  localparam int unsigned CYCLE_LIMIT      = 200000;
  localparam int unsigned PHASES           = 5;
  localparam int unsigned RANDOM_PER_PHASE = 80;
  localparam int unsigned NUM_REGS         = 5;
  localparam int unsigned DRAIN_CYCLES     = 8;
  localparam int unsigned NUM_CMDS         = 1 << CMD_W;

  localparam logic [CMD_W-1:0] FIRST_BAD_CMD = CMD_TLS_MARKER + 1;
  localparam logic [CMD_W-1:0] LAST_BAD_CMD  = '1;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [DATA_W-1:0] sym_addr;
    logic [DATA_W-1:0] addend;
    logic [DATA_W-1:0] place;
    logic [DATA_W-1:0] got_entry_addr;
    logic [DATA_W-1:0] tlsgd_addr;
    logic [DATA_W-1:0] gottp_addr;
    logic [DATA_W-1:0] sym_size;
    logic [DATA_W-1:0] old_word;
  } reloc_t;

  typedef struct packed {
    logic [DATA_W-1:0] new_word;
    logic [SW_W-1:0]   store_width;
    logic              status;
  } patch_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [DATA_W-1:0]        cfg_wdata = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [CMD_W-1:0]         cmd = '0;
  logic [DATA_W-1:0]        sym_addr = '0;
  logic signed [DATA_W-1:0] addend = '0;
  logic [DATA_W-1:0]        place = '0;
  logic [DATA_W-1:0]        got_entry_addr = '0;
  logic [DATA_W-1:0]        tlsgd_addr = '0;
  logic [DATA_W-1:0]        gottp_addr = '0;
  logic [DATA_W-1:0]        sym_size = '0;
  logic [DATA_W-1:0]        old_word = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [DATA_W-1:0]        new_word;
  logic [SW_W-1:0]          store_width;
  logic                     status;

  logic [DATA_W-1:0] base_regs [NUM_REGS];
  reloc_t            queued_relocs [$];
  reloc_t            driven_reloc;
  patch_t            awaited_patches [$];
  int                send_idle_pct = 0;
  int                recv_stall_pct = 0;
  int                fail_count = 0;
  int unsigned       cycle_count = 0;

  sparc64_relocation_patcher_core dut (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [21:0] hix22_of(input logic [DATA_W-1:0] v);
    logic signed [DATA_W-1:0] sv;
    logic signed [DATA_W-1:0] sh10;
    logic signed [DATA_W-1:0] sh31;
    logic [DATA_W-1:0]        t;
    sv = v;
    sh10 = sv >>> 10;
    sh31 = sv >>> 31;
    t = sh10 ^ sh31;
    return t[21:0];
  endfunction

  function automatic logic [12:0] lox10_of(input logic [DATA_W-1:0] v);
    logic signed [DATA_W-1:0] sv;
    logic signed [DATA_W-1:0] sh31;
    logic [DATA_W-1:0]        t;
    sv = v;
    sh31 = sv >>> 31;
    t = {54'b0, v[9:0]} | (sh31 & {51'b0, LOX_SET});
    return t[12:0];
  endfunction

  function automatic patch_t patch_for(input reloc_t r);
    logic [DATA_W-1:0] sa, sap, g, tlsgd, gottp, ldm, ldo, le, call_disp, inv, f;
    logic [SW_W-1:0]   sw;
    logic              st;
    logic              ovr;
    patch_t            p;
    sa = r.sym_addr + r.addend;
    sap = sa - r.place;
    g = r.got_entry_addr - base_regs[CFG_GOT_BASE];
    tlsgd = r.tlsgd_addr + r.addend - base_regs[CFG_GOT_BASE];
    gottp = r.gottp_addr + r.addend - base_regs[CFG_GOT_BASE];
    ldm = base_regs[CFG_TLS_MODULE_SLOT] + r.addend - base_regs[CFG_GOT_BASE];
    ldo = sa - base_regs[CFG_TLS_BLOCK_START];
    le = sa - base_regs[CFG_THREAD_POINTER];
    call_disp = base_regs[CFG_TLS_HELPER_ADDR] + r.addend - r.place;
    inv = '0;
    f = '0;
    sw = SW_WORD;
    st = ST_OK;
    ovr = 1'b0;
    case (r.cmd)
      CMD_R5:               f = sa[4:0];
      CMD_R6:               f = sa[5:0];
      CMD_R7:               f = sa[6:0];
      CMD_R8: begin
        f = sa[7:0];
        sw = SW_BYTE;
        ovr = 1'b1;
      end
      CMD_R10:              f = sa[9:0];
      CMD_R11:              f = sa[10:0];
      CMD_R13:              f = sa[12:0];
      CMD_R22:              f = sa[21:0];
      CMD_R16: begin
        f = sa[15:0];
        sw = SW_HALF;
        ovr = 1'b1;
      end
      CMD_R32: begin
        f = sa[31:0];
        ovr = 1'b1;
      end
      CMD_DISP8: begin
        f = sap[7:0];
        sw = SW_BYTE;
        ovr = 1'b1;
      end
      CMD_DISP16: begin
        f = sap[15:0];
        sw = SW_HALF;
        ovr = 1'b1;
      end
      CMD_DISP32: begin
        f = sap[31:0];
        ovr = 1'b1;
      end
      CMD_WDISP22:          f = sap[23:2];
      CMD_WDISP30:          f = sap[31:2];
      CMD_HI22:             f = sa[31:10];
      CMD_GOT10:            f = g[9:0];
      CMD_GOT13:            f = g[12:0];
      CMD_GOT22:            f = g[31:10];
      CMD_GOTDATA_HIX22:    f = hix22_of(sa - base_regs[CFG_GOT_BASE]);
      CMD_GOTDATA_OP_HIX22: f = hix22_of(g);
      CMD_GOTDATA_LOX10:    f = lox10_of(sa - base_regs[CFG_GOT_BASE]);
      CMD_GOTDATA_OP_LOX10: f = lox10_of(g);
      CMD_GOTDATA_OP:       sw = SW_NONE;
      CMD_PC10:             f = sap[9:0];
      CMD_PC22:             f = sap[31:10];
      CMD_OLO10:            f = sa[9:0];
      CMD_HH22:             f = sa[63:42];
      CMD_HM10:             f = sa[41:32];
      CMD_PC_HH22:          f = sap[63:42];
      CMD_PC_HM10:          f = sap[41:32];
      CMD_WDISP16: begin
        f[21:20] = sap[17:16];
        f[13:0] = sap[15:2];
      end
      CMD_WDISP19:          f = sap[20:2];
      CMD_DISP64: begin
        f = sap;
        sw = SW_DOUBLE;
        ovr = 1'b1;
      end
      CMD_R64: begin
        f = sa;
        sw = SW_DOUBLE;
        ovr = 1'b1;
      end
      CMD_HIX22: begin
        inv = ~sa;
        f = inv[31:10];
      end
      CMD_LOX10:            f = {54'b0, sa[9:0]} | {51'b0, LOX_SET};
      CMD_H44:              f = sa[43:22];
      CMD_M44:              f = sa[21:12];
      CMD_L44:              f = sa[11:0];
      CMD_TLS_GD_HI22:      f = tlsgd[31:10];
      CMD_TLS_GD_LO10:      f = tlsgd[9:0];
      CMD_TLS_CALL:         f = call_disp[31:2];
      CMD_TLS_LDM_HI22:     f = ldm[31:10];
      CMD_TLS_LDM_LO10:     f = ldm[9:0];
      CMD_TLS_LDO_HIX22:    f = ldo[31:10];
      CMD_TLS_LDO_LOX10:    f = ldo[9:0];
      CMD_TLS_IE_HI22:      f = gottp[31:10];
      CMD_TLS_IE_LO10:      f = gottp[9:0];
      CMD_TLS_LE_HIX22: begin
        inv = ~le;
        f = inv[31:10];
      end
      CMD_TLS_LE_LOX10:     f = {54'b0, le[9:0]} | {51'b0, LOX_SET};
      CMD_SIZE32: begin
        inv = r.sym_size + r.addend;
        f = inv[31:0];
        ovr = 1'b1;
      end
      CMD_TLS_MARKER:       sw = SW_NONE;
      default: begin
        sw = SW_NONE;
        st = ST_BAD_KIND;
      end
    endcase
    p.store_width = sw;
    p.status = st;
    if (sw == SW_NONE) begin
      p.new_word = '0;
    end else if (ovr) begin
      p.new_word = f;
    end else begin
      p.new_word = {32'b0, r.old_word[31:0] | f[31:0]};
    end
    return p;
  endfunction

  function automatic logic [DATA_W-1:0] rand_word();
    logic [DATA_W-1:0] w;
    case ($urandom_range(9))
      0:       w = '0;
      1:       w = '1;
      2:       w = {1'b1, 63'b0};
      3:       w = {1'b0, {63{1'b1}}};
      4:       w = {52'b0, 12'($urandom)};
      5:       w = -{52'b0, 12'($urandom)};
      default: w = {$urandom, $urandom};
    endcase
    return w;
  endfunction

  // one draw in four lands near a base so offset fields see small values of both signs
  function automatic logic [DATA_W-1:0] rand_addr();
    logic [11:0] near;
    near = 12'($urandom);
    if ($urandom_range(3) == 0) begin
      return base_regs[$urandom_range(NUM_REGS-1)] + {{52{near[11]}}, near};
    end
    return rand_word();
  endfunction

  function automatic reloc_t random_reloc(input logic [CMD_W-1:0] kind);
    reloc_t r;
    r.cmd = kind;
    r.sym_addr = rand_addr();
    r.addend = rand_word();
    r.place = rand_addr();
    r.got_entry_addr = rand_addr();
    r.tlsgd_addr = rand_addr();
    r.gottp_addr = rand_addr();
    r.sym_size = rand_word();
    r.old_word = {$urandom, $urandom};
    return r;
  endfunction

  task automatic program_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    base_regs[idx] = val;
  endtask

  always @(posedge clk) begin : drive_relocs
    reloc_t next_reloc;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        awaited_patches.push_back(patch_for(driven_reloc));
      end
      if (!in_valid || in_ready) begin
        if (queued_relocs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_reloc = queued_relocs.pop_front();
          driven_reloc <= next_reloc;
          cmd <= next_reloc.cmd;
          sym_addr <= next_reloc.sym_addr;
          addend <= next_reloc.addend;
          place <= next_reloc.place;
          got_entry_addr <= next_reloc.got_entry_addr;
          tlsgd_addr <= next_reloc.tlsgd_addr;
          gottp_addr <= next_reloc.gottp_addr;
          sym_size <= next_reloc.sym_size;
          old_word <= next_reloc.old_word;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_patches
    patch_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_patches.size() == 0) begin
          $error("unexpected item: new_word %h store_width %0d status %0d",
                 new_word, store_width, status);
          fail_count++;
        end else begin
          want = awaited_patches.pop_front();
          if (new_word !== want.new_word) begin
            $error("new_word: expected %h, got %h", want.new_word, new_word);
            fail_count++;
          end
          if (store_width !== want.store_width) begin
            $error("store_width: expected %0d, got %0d", want.store_width, store_width);
            fail_count++;
          end
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            fail_count++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin : run_phases
    reloc_t            r;
    logic [DATA_W-1:0] val;
    logic [CMD_W-1:0]  kind;
    for (int k = 0; k < NUM_REGS; k++) base_regs[k] = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (int phase = 0; phase < PHASES; phase++) begin
      for (int k = 0; k < NUM_REGS; k++) begin
        case (phase)
          0:       val = '0;
          1:       val = '1;
          3: begin
            if (k == CFG_GOT_BASE) val = {1'b1, 63'b0};
            else if (k == CFG_TLS_BLOCK_START) val = {1'b0, {63{1'b1}}};
            else val = {$urandom, $urandom};
          end
          4:       val = {52'b0, 12'($urandom)};
          default: val = {$urandom, $urandom};
        endcase
        program_reg(k[CFG_IDX_W-1:0], val);
      end
      @(posedge clk);
      cfg_we <= 1'b0;

      case (phase)
        1: begin
          send_idle_pct = 70;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 70;
        end
        3: begin
          send_idle_pct = 28;
          recv_stall_pct = 28;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
      endcase

      if (phase == 0) begin
        r = '0;
        r.cmd = CMD_R5;
        queued_relocs.push_back(r);
        r = '1;
        r.cmd = CMD_R64;
        queued_relocs.push_back(r);
        r.cmd = CMD_R32;
        queued_relocs.push_back(r);
        r = random_reloc(CMD_DISP64);
        r.sym_addr = '0; r.addend = '0; r.place = 64'd1;
        queued_relocs.push_back(r);
        r = random_reloc(CMD_R64);
        r.sym_addr = '1; r.addend = {1'b1, 63'b0};
        queued_relocs.push_back(r);
        r = random_reloc(CMD_R64);
        r.sym_addr = '0; r.addend = {1'b0, {63{1'b1}}};
        queued_relocs.push_back(r);
        queued_relocs.push_back(random_reloc(CMD_GOTDATA_OP));
        queued_relocs.push_back(random_reloc(CMD_TLS_MARKER));
        queued_relocs.push_back(random_reloc(FIRST_BAD_CMD));
        queued_relocs.push_back(random_reloc(LAST_BAD_CMD));
        r = random_reloc(CMD_R8);
        r.old_word = '1;
        queued_relocs.push_back(r);
        r = random_reloc(CMD_R22);
        r.old_word = {32'hffff_ffff, 32'h0};
        queued_relocs.push_back(r);
        r = random_reloc(CMD_PC_HH22);
        r.sym_addr = '1; r.addend = '0; r.place = '0;
        queued_relocs.push_back(r);
        r = random_reloc(CMD_WDISP16);
        r.sym_addr = 64'h3_fffc; r.addend = '0; r.place = '0;
        queued_relocs.push_back(r);
        r.sym_addr = 64'h2_0004;
        queued_relocs.push_back(r);
        r = random_reloc(CMD_GOTDATA_HIX22);
        r.sym_addr = 64'hffff_ffff_8000_1234; r.addend = '0;
        queued_relocs.push_back(r);
        r.sym_addr = 64'h0000_0000_7fff_1234;
        queued_relocs.push_back(r);
        r = random_reloc(CMD_GOTDATA_OP_LOX10);
        r.got_entry_addr = 64'hffff_ffff_8000_03ff;
        queued_relocs.push_back(r);
        r = random_reloc(CMD_GOTDATA_OP_HIX22);
        r.got_entry_addr = 64'h0000_1234_5678_9abc;
        queued_relocs.push_back(r);
        r = random_reloc(CMD_HIX22);
        r.sym_addr = '0; r.addend = '0;
        queued_relocs.push_back(r);
        r = random_reloc(CMD_SIZE32);
        r.sym_size = '1; r.addend = 64'd1;
        queued_relocs.push_back(r);
        r = random_reloc(CMD_TLS_LE_LOX10);
        r.sym_addr = '1; r.addend = '0;
        queued_relocs.push_back(r);
      end

      // sweep every kind once in the first phase, then draw mostly known kinds
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        if (phase == 0 && i < NUM_CMDS) begin
          kind = i[CMD_W-1:0];
        end else if ($urandom_range(99) < 85) begin
          kind = CMD_W'($urandom_range(int'(CMD_TLS_MARKER)));
        end else begin
          kind = CMD_W'($urandom_range(int'(LAST_BAD_CMD), int'(FIRST_BAD_CMD)));
        end
        queued_relocs.push_back(random_reloc(kind));
      end

      while (queued_relocs.size() != 0 || in_valid || awaited_patches.size() != 0) begin
        @(posedge clk);
      end
      repeat (DRAIN_CYCLES) @(posedge clk);
    end

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
